/* rtl/core/wla_pkg.sv */
// ============================================================================
// wla_pkg
// Shared types and constants for the water level alarm sequencer.
// ============================================================================
`default_nettype none

package wla_pkg;

    localparam int unsigned LEVEL_W = 8;
    localparam int unsigned CNT_W   = 16;
    localparam int unsigned UNIT_W  = 14;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned IDX_W   = 2;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [IDX_W-1:0] REG_QUALIFY_LIMIT   = 2'd0;
    localparam logic [IDX_W-1:0] REG_FULL_LEVEL      = 2'd1;
    localparam logic [IDX_W-1:0] REG_BEEP_UNIT       = 2'd2;
    localparam logic [IDX_W-1:0] REG_LONG_BEEP_TICKS = 2'd3;

    localparam logic [CNT_W-1:0]   RST_QUALIFY_LIMIT   = 16'd5000;
    localparam logic [LEVEL_W-1:0] RST_FULL_LEVEL      = 8'd98;
    localparam logic [UNIT_W-1:0]  RST_BEEP_UNIT       = 14'd500;
    localparam logic [CNT_W-1:0]   RST_LONG_BEEP_TICKS = 16'd3000;

    typedef struct packed {
        logic [CNT_W-1:0]   qualify_limit;
        logic [LEVEL_W-1:0] full_level;
        logic [UNIT_W-1:0]  beep_unit;
        logic [CNT_W-1:0]   long_beep_ticks;
    } cfg_t;

    typedef struct packed {
        logic en;
        logic rise_empty;
        logic rise_full;
    } alarm_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/wla_qualify.sv */
// ============================================================================
// wla_qualify
// Saturating persistence counter; flags a set once a condition outlasts the limit.
// ============================================================================
`default_nettype none

module wla_qualify (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     en,
    input  wire logic                     cond,
    input  wire logic [wla_pkg::CNT_W-1:0] limit,
    output logic                          set
);
    import wla_pkg::*;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] cnt_inc;

    always_comb
    begin
        cnt_inc  = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + 1'b1;
        set      = cond && (cnt_inc > limit);
        cnt_next = (!cond || set) ? '0 : cnt_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (en)
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/wla_alarm.sv */
// ============================================================================
// wla_alarm
// Empty-tank beep pattern and full-tank long beep sharing one buzzer pin.
// ============================================================================
`default_nettype none

module wla_alarm (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire wla_pkg::alarm_ctl_t ctl,
    input  wire wla_pkg::cfg_t       cfg,
    output logic                     pin_next
);
    import wla_pkg::*;

    logic             run_e_reg;
    logic             run_e_next;
    logic             run_f_reg;
    logic             run_f_next;
    logic [CNT_W-1:0] pat_reg;
    logic [CNT_W-1:0] pat_next;
    logic [CNT_W-1:0] long_reg;
    logic [CNT_W-1:0] long_next;
    logic             pin_reg;
    logic [CNT_W:0]   u1;
    logic [CNT_W:0]   u2;
    logic [CNT_W:0]   u3;
    logic [CNT_W:0]   pc;
    logic             pin_mid;
    logic             act_e;
    logic             act_f;

    always_comb
    begin
        u1 = {{(CNT_W+1-UNIT_W){1'b0}}, cfg.beep_unit};
        u2 = u1 << 1;
        u3 = u2 + u1;

        act_e      = run_e_reg || ctl.rise_empty;
        run_e_next = act_e;
        pin_mid    = pin_reg;
        pat_next   = '0;
        pc         = '0;
        if (act_e)
        begin
            pat_next = pat_reg + 1'b1;
            pc       = {1'b0, pat_next};
            if ((pc != '0) && (pc < u1))
                pin_mid = 1'b1;
            if ((pc > u1) && (pc < u2))
                pin_mid = 1'b0;
            if ((pc > u2) && (pc < u3))
                pin_mid = 1'b1;
            if (pc > u3)
            begin
                pin_mid    = 1'b0;
                run_e_next = 1'b0;
            end
        end

        act_f      = run_f_reg || ctl.rise_full;
        run_f_next = act_f;
        pin_next   = pin_mid;
        long_next  = '0;
        if (act_f)
        begin
            long_next = long_reg + 1'b1;
            if (long_next < cfg.long_beep_ticks)
            begin
                pin_next = 1'b1;
            end
            else
            begin
                pin_next   = 1'b0;
                run_f_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_e_reg <= 1'b0;
            run_f_reg <= 1'b0;
            pat_reg   <= '0;
            long_reg  <= '0;
            pin_reg   <= 1'b0;
        end
        else if (ctl.en)
        begin
            run_e_reg <= run_e_next;
            run_f_reg <= run_f_next;
            pat_reg   <= pat_next;
            long_reg  <= long_next;
            pin_reg   <= pin_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/water_level_alarm_sequencer_core.sv */
// ============================================================================
// water_level_alarm_sequencer_core
// Qualifies level ticks into empty/full flags and sequences the buzzer alarms.
// ============================================================================
// Each accepted word is registered in the input register, then in the result register.
// Throughput: one word per cycle unless m_tready stalls; each register holds one.
// Reset: asynchronous, active low; counters clear, flags clear, alarms idle,
// buzzer off, configuration returns to its defaults.
`default_nettype none

module water_level_alarm_sequencer_core (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [wla_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [wla_pkg::CFG_W-1:0] cfg_data,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [7:0]                s_tdata,   // [7:0] water_level
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [7:0]                     m_tdata    // [0] buzzer_on, [1] tank_empty,
                                                      // [2] tank_full, [7:3] zero
);
    import wla_pkg::*;

    cfg_t               cfg_reg;
    logic               in_valid_reg;
    logic [LEVEL_W-1:0] in_level_reg;
    logic               out_valid_reg;
    logic [2:0]         out_data_reg;
    logic               empty_reg;
    logic               empty_next;
    logic               full_reg;
    logic               full_next;
    logic               advance;
    logic               step;
    logic               set_empty;
    logic               set_water;
    logic               set_full;
    logic               set_notfull;
    logic               pin_next;
    alarm_ctl_t         actl;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign step     = in_valid_reg && advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_data_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.qualify_limit   <= RST_QUALIFY_LIMIT;
            cfg_reg.full_level      <= RST_FULL_LEVEL;
            cfg_reg.beep_unit       <= RST_BEEP_UNIT;
            cfg_reg.long_beep_ticks <= RST_LONG_BEEP_TICKS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_QUALIFY_LIMIT:   cfg_reg.qualify_limit   <= cfg_data;
                REG_FULL_LEVEL:      cfg_reg.full_level      <= cfg_data[LEVEL_W-1:0];
                REG_BEEP_UNIT:       cfg_reg.beep_unit       <= cfg_data[UNIT_W-1:0];
                REG_LONG_BEEP_TICKS: cfg_reg.long_beep_ticks <= cfg_data;
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_level_reg <= s_tdata[LEVEL_W-1:0];
    end

    wla_qualify u_q_empty (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (step),
        .cond  (in_level_reg == '0),
        .limit (cfg_reg.qualify_limit),
        .set   (set_empty)
    );

    wla_qualify u_q_water (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (step),
        .cond  (in_level_reg != '0),
        .limit (cfg_reg.qualify_limit),
        .set   (set_water)
    );

    wla_qualify u_q_full (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (step),
        .cond  (in_level_reg > cfg_reg.full_level),
        .limit (cfg_reg.qualify_limit),
        .set   (set_full)
    );

    wla_qualify u_q_notfull (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (step),
        .cond  (in_level_reg < cfg_reg.full_level),
        .limit (cfg_reg.qualify_limit),
        .set   (set_notfull)
    );

    always_comb
    begin
        empty_next = set_water ? 1'b0 : (set_empty ? 1'b1 : empty_reg);
        full_next  = set_notfull ? 1'b0 : (set_full ? 1'b1 : full_reg);
        actl.en         = step;
        actl.rise_empty = empty_next && !empty_reg;
        actl.rise_full  = full_next && !full_reg;
    end

    wla_alarm u_alarm (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (actl),
        .cfg      (cfg_reg),
        .pin_next (pin_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_reg     <= 1'b0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                empty_reg <= empty_next;
                full_reg  <= full_next;
            end
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_data_reg <= {full_next, empty_next, pin_next};
    end

endmodule

`default_nettype wire

/* sim/water_level_alarm_sequencer_core_tb.sv */
// ----------------------------------------------------------------------------
// water_level_alarm_sequencer_core_tb
// Drives level ticks through the stream port under random idling on both sides,
// predicts each result word from a cycle-free model of the qualify counters and
// buzzer sequencing, and checks buzzer, empty and full bits in order.
// ----------------------------------------------------------------------------
`default_nettype none

module water_level_alarm_sequencer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wla_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic buzzer_on;
        logic tank_empty;
        logic tank_full;
    } alarm_word_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [IDX_W-1:0]  cfg_index = REG_QUALIFY_LIMIT;
    logic [CFG_W-1:0]  cfg_data = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata = '0;     // [7:0] water_level
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [7:0]        m_tdata;          // [0] buzzer_on, [1] tank_empty, [2] tank_full

    // model configuration
    logic [CNT_W-1:0]   lim_qualify   = RST_QUALIFY_LIMIT;
    logic [LEVEL_W-1:0] lim_full      = RST_FULL_LEVEL;
    logic [UNIT_W-1:0]  beep_seg      = RST_BEEP_UNIT;
    logic [CNT_W-1:0]   long_len      = RST_LONG_BEEP_TICKS;

    // model state
    logic [CNT_W-1:0]   run_dry = '0;
    logic [CNT_W-1:0]   run_wet = '0;
    logic [CNT_W-1:0]   run_over = '0;
    logic [CNT_W-1:0]   run_under = '0;
    logic               flag_dry = 1'b0;
    logic               flag_full = 1'b0;
    logic               seen_dry = 1'b0;
    logic               seen_full = 1'b0;
    logic               pattern_on = 1'b0;
    logic               long_on = 1'b0;
    logic [CNT_W-1:0]   pattern_ticks = '0;
    logic [CNT_W-1:0]   long_ticks = '0;
    logic               pin = 1'b0;

    alarm_word_t        alarm_q[$];
    alarm_word_t        want;
    int                 fail_count = 0;
    int                 words_checked = 0;
    int                 quiet_cycles = 0;
    bit                 steady = 1'b0;

    water_level_alarm_sequencer_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #4 clk = ~clk;

    function automatic logic qualify_step(inout logic [CNT_W-1:0] cnt, input logic cond);
        if (!cond)
        begin
            cnt = '0;
            return 1'b0;
        end
        if (cnt != CNT_MAX)
            cnt = cnt + 1'b1;
        if (cnt > lim_qualify)
        begin
            cnt = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic alarm_word_t predict_tick(input logic [7:0] lvl);
        int unsigned u1;
        int unsigned u2;
        int unsigned u3;
        alarm_word_t w;
        u1 = 32'(beep_seg);
        u2 = 2 * u1;
        u3 = 3 * u1;
        if (qualify_step(run_dry, lvl == 8'd0))
            flag_dry = 1'b1;
        if (qualify_step(run_wet, lvl != 8'd0))
            flag_dry = 1'b0;
        if (seen_dry != flag_dry)
        begin
            seen_dry = flag_dry;
            if (flag_dry)
                pattern_on = 1'b1;
        end
        if (pattern_on)
        begin
            pattern_ticks = pattern_ticks + 1'b1;
            if (pattern_ticks > 0 && pattern_ticks < u1)
                pin = 1'b1;
            if (pattern_ticks > u1 && pattern_ticks < u2)
                pin = 1'b0;
            if (pattern_ticks > u2 && pattern_ticks < u3)
                pin = 1'b1;
            if (pattern_ticks > u3)
            begin
                pin = 1'b0;
                pattern_on = 1'b0;
            end
        end
        else
            pattern_ticks = '0;
        if (qualify_step(run_over, lvl > lim_full))
            flag_full = 1'b1;
        if (qualify_step(run_under, lvl < lim_full))
            flag_full = 1'b0;
        if (seen_full != flag_full)
        begin
            seen_full = flag_full;
            if (flag_full)
                long_on = 1'b1;
        end
        if (long_on)
        begin
            long_ticks = long_ticks + 1'b1;
            if (long_ticks < long_len)
                pin = 1'b1;
            else
            begin
                long_on = 1'b0;
                pin = 1'b0;
            end
        end
        else
            long_ticks = '0;
        w.buzzer_on  = pin;
        w.tank_empty = flag_dry;
        w.tank_full  = flag_full;
        return w;
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task automatic send_level(input logic [7:0] lvl);
        while (!steady && $urandom_range(99, 0) < 28)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= lvl;
        do
            @(posedge clk);
        while (!s_tready);
        alarm_q.push_back(predict_tick(lvl));
    endtask

    // hold off the sender until every pending word has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (alarm_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_config(input logic [CNT_W-1:0] q, input logic [LEVEL_W-1:0] fl,
                              input logic [UNIT_W-1:0] bu, input logic [CNT_W-1:0] lb);
        logic [15:0] junk;
        junk = 16'($urandom());
        cfg_we    <= 1'b1;
        cfg_index <= REG_QUALIFY_LIMIT;
        cfg_data  <= q;
        @(posedge clk);
        cfg_index <= REG_FULL_LEVEL;
        cfg_data  <= {junk[7:0], fl};
        @(posedge clk);
        cfg_index <= REG_BEEP_UNIT;
        cfg_data  <= {junk[9:8], bu};
        @(posedge clk);
        cfg_index <= REG_LONG_BEEP_TICKS;
        cfg_data  <= lb;
        @(posedge clk);
        cfg_we <= 1'b0;
        lim_qualify = q;
        lim_full    = fl;
        beep_seg    = bu;
        long_len    = lb;
    endtask

    task automatic test_reset_defaults();
        send_level(8'd0);
        send_level(8'd255);
        send_level(8'd98);
        send_level(8'd97);
        send_level(8'd99);
        send_level(8'd1);
        drain_results();
    endtask

    task automatic test_directed_corners();
        int k;
        // immediate qualify, single-tick beep segments
        set_config(16'd0, 8'd98, 14'd1, 16'd2);
        for (k = 0; k < 5; k++)
            send_level(8'd0);
        send_level(8'd255);
        send_level(8'd255);
        send_level(8'd255);
        send_level(8'd98);
        send_level(8'd97);
        send_level(8'd255);
        drain_results();
        // zero unit and zero length end their alarms at once
        set_config(16'd1, 8'd0, 14'd0, 16'd0);
        send_level(8'd0);
        send_level(8'd0);
        send_level(8'd0);
        send_level(8'd5);
        send_level(8'd5);
        send_level(8'd5);
        drain_results();
        // saturating counters never qualify
        set_config(16'hFFFF, 8'd255, 14'h3FFF, 16'hFFFF);
        send_level(8'd0);
        send_level(8'd255);
        send_level(8'd0);
        drain_results();
    endtask

    task automatic test_random_levels();
        int phase;
        int sent;
        int run;
        int kind;
        int k;
        logic [7:0] lvl;
        for (phase = 0; phase < 8; phase++)
        begin
            case (phase)
                1: set_config(16'($urandom_range(4, 0)), 8'd0, 14'($urandom_range(4, 1)),
                              16'($urandom_range(10, 1)));
                2: set_config(16'($urandom_range(6, 0)), 8'd255, 14'($urandom_range(3, 1)),
                              16'($urandom_range(8, 1)));
                3: set_config(16'd2, 8'($urandom_range(255, 0)), 14'h3FFF, 16'hFFFF);
                default: set_config(16'($urandom_range(8, 0)), 8'($urandom_range(255, 0)),
                                    14'($urandom_range(5, 1)), 16'($urandom_range(12, 1)));
            endcase
            steady = (phase == 2);
            sent = 0;
            while (sent < 50)
            begin
                kind = $urandom_range(9, 0);
                run = $urandom_range(int'(lim_qualify) + 4, 1);
                if (run > 24)
                    run = 24;
                if (kind == 9)
                    run = $urandom_range(3, 1);
                for (k = 0; k < run && sent < 50; k++)
                begin
                    if (kind <= 2)
                        lvl = 8'd0;
                    else if (kind <= 4)
                        lvl = lim_full;
                    else if (kind <= 6)
                        lvl = (lim_full == 8'd255) ? 8'($urandom())
                              : 8'($urandom_range(255, int'(lim_full) + 1));
                    else if (kind <= 8)
                        lvl = (lim_full <= 8'd1) ? 8'($urandom())
                              : 8'($urandom_range(int'(lim_full) - 1, 1));
                    else
                        lvl = 8'($urandom());
                    send_level(lvl);
                    sent++;
                    if (phase == 5 && sent == 25)
                        drain_results();
                end
            end
            drain_results();
        end
        steady = 1'b0;
    endtask

    always @(posedge clk)
        m_tready <= steady || ($urandom_range(99, 0) >= 28);

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            if (alarm_q.size() == 0)
                report_mismatch("result word with nothing pending");
            else
            begin
                want = alarm_q.pop_front();
                if (m_tdata[0] !== want.buzzer_on)
                    report_mismatch($sformatf("word %0d buzzer_on got %b want %b",
                                              words_checked, m_tdata[0], want.buzzer_on));
                if (m_tdata[1] !== want.tank_empty)
                    report_mismatch($sformatf("word %0d tank_empty got %b want %b",
                                              words_checked, m_tdata[1], want.tank_empty));
                if (m_tdata[2] !== want.tank_full)
                    report_mismatch($sformatf("word %0d tank_full got %b want %b",
                                              words_checked, m_tdata[2], want.tank_full));
                words_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_directed_corners();
        test_random_levels();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && alarm_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
